>>> hdl/stick_to_velocity_command_unit_defines.svh
// Assertion macros for the stick to velocity command unit checker.
// Used by the checker file; depends on nothing else.
`ifndef STICK_TO_VELOCITY_COMMAND_UNIT_DEFINES_SVH
`define STICK_TO_VELOCITY_COMMAND_UNIT_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define SVC_ASSERT_IMPL(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence in the following cycle.
`define SVC_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/svc_pkg.sv
// Package for the stick to velocity command unit: codes, widths, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps

package svc_pkg;

    localparam int NUM_AXES_DEF = 8;

    localparam logic [1:0] ACT_AXIS   = 2'd0;
    localparam logic [1:0] ACT_BUTTON = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [2:0] REG_MAPPING  = 3'd0;
    localparam logic [2:0] REG_DEADBAND = 3'd1;
    localparam logic [2:0] REG_GAIN     = 3'd2;
    localparam logic [2:0] REG_SPEED    = 3'd3;
    localparam logic [2:0] REG_CLIMB    = 3'd4;
    localparam logic [2:0] REG_YAWSTEP  = 3'd5;

    localparam int CORDIC_STEPS = 14;

    // Queue entry between the front and the back part.
    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         number;
        logic signed [15:0] value;
        logic               estimate_valid;
        logic signed [15:0] vehicle_yaw;
    } item_t;

    typedef struct packed {
        logic               send_command;
        logic               mode_fly;
        logic signed [14:0] vel_north;
        logic signed [14:0] vel_east;
        logic signed [14:0] vel_down;
        logic signed [15:0] yaw_reference;
        logic               arm_refused;
    } result_t;

    typedef struct packed {
        logic        mapping_radio;
        logic [14:0] deadband;
        logic [15:0] rescale_gain;
        logic [13:0] speed_max;
        logic [13:0] climb_max;
        logic [12:0] yaw_step;
    } cfg_t;

    function automatic logic [13:0] cordic_atan(input logic [3:0] i);
        logic [13:0] r;
        begin
            case (i)
                4'd0:    r = 14'd8192;
                4'd1:    r = 14'd4836;
                4'd2:    r = 14'd2555;
                4'd3:    r = 14'd1297;
                4'd4:    r = 14'd651;
                4'd5:    r = 14'd326;
                4'd6:    r = 14'd163;
                4'd7:    r = 14'd81;
                4'd8:    r = 14'd41;
                4'd9:    r = 14'd20;
                4'd10:   r = 14'd10;
                4'd11:   r = 14'd5;
                4'd12:   r = 14'd3;
                4'd13:   r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hdl/svc_queue.sv
// Two-entry queue between the front and back parts.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_queue
    import svc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_wr;
    logic do_rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

>>> hdl/svc_back.sv
// Back part: keeps axis values and arm state, runs a tick over a sequencer
// with one shared multiplier and an iterative CORDIC. Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_back
    import svc_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result,
    output logic    busy
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_STICK  = 10'b0000000010,
        ST_ARM    = 10'b0000000100,
        ST_YAW    = 10'b0000001000,
        ST_CORDIC = 10'b0000010000,
        ST_ROT    = 10'b0000100000,
        ST_SCALE  = 10'b0001000000,
        ST_DOWN   = 10'b0010000000,
        ST_OUT    = 10'b0100000000,
        ST_HOLD   = 10'b1000000000
    } state_t;

    localparam int AXW = $clog2(NUM_AXES);

    state_t state_reg, state_next;

    logic [15:0] axis_reg [NUM_AXES];
    logic switch_seen_reg, armed_reg, refused_reg, engaged_reg;
    logic heading_known_reg, prev_known_reg, prev_on_reg;
    logic [15:0] yaw_accum_reg;

    item_t cur_reg;
    logic [1:0] stick_idx_reg;
    logic signed [16:0] stick_reg [4];   // climb, yaw, fwd, right
    logic [3:0] iter_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [15:0] cz_reg;
    logic cneg_reg;
    logic signed [16:0] cos_reg, sin_reg;
    logic [1:0] rot_idx_reg;
    logic signed [34:0] acc_reg;
    logic signed [35:0] vn_reg, ve_reg;
    logic [1:0] sc_idx_reg;
    logic signed [14:0] vn_out_reg, ve_out_reg, vd_out_reg;
    logic out_valid_reg;
    result_t out_reg;

    // Shared multiplier: signed 18 x signed 18.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Stick shaping of one axis.
    logic [15:0]        raw_sel;
    logic signed [15:0] raw_s;
    logic [16:0]        raw_mag;
    logic [16:0]        above_db;
    logic [32:0]        shaped_prod;
    logic [17:0]        shaped_mag;
    logic [14:0]        shaped_sat;
    logic signed [16:0] shaped_val;
    logic               shape_neg;
    logic               radio;

    assign radio = cfg.mapping_radio;

    always_comb
    begin
        logic [2:0] ai;
        ai = 3'd0;
        shape_neg = 1'b0;
        unique case (stick_idx_reg)
            2'd0:    begin ai = radio ? 3'd2 : 3'd1; shape_neg = !radio; end
            2'd1:    begin ai = radio ? 3'd3 : 3'd0; end
            2'd2:    begin ai = radio ? 3'd1 : 3'd4; shape_neg = !radio; end
            default: begin ai = radio ? 3'd0 : 3'd3; end
        endcase
        raw_sel = axis_reg[AXW'(ai)];
    end

    assign raw_s       = raw_sel;
    assign raw_mag     = raw_s[15] ? (17'd0 - {raw_s[15], raw_s}) : {1'b0, raw_s};
    assign above_db    = raw_mag - {2'b00, cfg.deadband};
    assign shaped_prod = above_db * cfg.rescale_gain;
    assign shaped_mag  = shaped_prod[32:15];
    assign shaped_sat  = (raw_mag <= {2'b00, cfg.deadband}) ? 15'd0 :
                         ((shaped_mag > 18'd32767) ? 15'h7fff : shaped_mag[14:0]);
    assign shaped_val  = ((raw_s[15] ^ shape_neg) ? -$signed({2'b00, shaped_sat})
                                                  :  $signed({2'b00, shaped_sat}));

    // Round half away from zero and saturation helpers.
    function automatic logic signed [35:0] rshift(input logic signed [35:0] v,
                                                  input int n);
        logic [35:0] m;
        begin
            m = v[35] ? -v : v;
            m = (m + (36'd1 << (n - 1))) >> n;
            return v[35] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [14:0] sat15(input logic signed [35:0] v);
        begin
            if (v > 36'sd16383) return 15'sd16383;
            if (v < -36'sd16384) return -15'sd16384;
            return v[14:0];
        end
    endfunction

    // CORDIC step.
    logic signed [32:0] sh_x, sh_y;
    logic signed [15:0] atan_v;
    assign sh_x   = cx_reg >>> iter_reg;
    assign sh_y   = cy_reg >>> iter_reg;
    assign atan_v = {2'b00, cordic_atan(iter_reg)};

    logic signed [35:0] yaw_rounded;
    logic signed [35:0] cx_rnd, cy_rnd;
    assign yaw_rounded = rshift(mul_p, 15);
    assign cx_rnd = rshift({{3{cx_reg[32]}}, cx_reg}, 15);
    assign cy_rnd = rshift({{3{cy_reg[32]}}, cy_reg}, 15);

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_YAW:
            begin
                mul_a = {stick_reg[1][16], stick_reg[1]};
                mul_b = {5'd0, cfg.yaw_step};
            end
            ST_ROT:
            begin
                unique case (rot_idx_reg)
                    2'd0:    begin mul_a = {cos_reg[16], cos_reg}; mul_b = {stick_reg[2][16], stick_reg[2]}; end
                    2'd1:    begin mul_a = {sin_reg[16], sin_reg}; mul_b = {stick_reg[3][16], stick_reg[3]}; end
                    2'd2:    begin mul_a = {sin_reg[16], sin_reg}; mul_b = {stick_reg[2][16], stick_reg[2]}; end
                    default: begin mul_a = {cos_reg[16], cos_reg}; mul_b = {stick_reg[3][16], stick_reg[3]}; end
                endcase
            end
            ST_DOWN:
            begin
                mul_a = -{stick_reg[0][16], stick_reg[0]};
                mul_b = {4'd0, cfg.climb_max};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Speed scaling: a 36-bit sum times 14 bits, split into low and high halves.
    logic signed [35:0] sc_src;
    logic signed [53:0] sc_lo, sc_hi;
    logic signed [53:0] sc_full;
    assign sc_src  = sc_idx_reg[0] ? ve_reg : vn_reg;
    assign sc_lo   = $signed({1'b0, sc_src[17:0]}) * $signed({1'b0, cfg.speed_max});
    assign sc_hi   = $signed(sc_src[35:18]) * $signed({1'b0, cfg.speed_max});
    assign sc_full = (sc_hi <<< 18) + sc_lo;

    function automatic logic signed [14:0] rnd30_sat(input logic signed [53:0] v);
        logic [53:0] m;
        logic signed [53:0] r;
        begin
            m = v[53] ? -v : v;
            m = (m + (54'd1 << 29)) >> 30;
            r = v[53] ? -$signed(m) : $signed(m);
            if (r > 54'sd16383) return 15'sd16383;
            if (r < -54'sd16384) return -15'sd16384;
            return r[14:0];
        end
    endfunction

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign busy       = (state_reg != ST_IDLE) || out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_item.action == ACT_TICK)
                begin
                    state_next = ST_STICK;
                end
            end
            ST_STICK:  if (stick_idx_reg == 2'd3) state_next = ST_ARM;
            ST_ARM:    state_next = cur_reg.estimate_valid ? ST_YAW : ST_OUT;
            ST_YAW:    state_next = ST_CORDIC;
            ST_CORDIC: if (iter_reg == 4'(CORDIC_STEPS)) state_next = ST_ROT;
            ST_ROT:    if (rot_idx_reg == 2'd3) state_next = ST_SCALE;
            ST_SCALE:  if (sc_idx_reg == 2'd1) state_next = ST_DOWN;
            ST_DOWN:   state_next = ST_OUT;
            ST_OUT:    state_next = out_valid_reg ? ST_OUT : ST_IDLE;
            ST_HOLD:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                axis_reg[i] <= 16'd0;
            end
            switch_seen_reg   <= 1'b0;
            armed_reg         <= 1'b0;
            refused_reg       <= 1'b0;
            engaged_reg       <= 1'b0;
            heading_known_reg <= 1'b0;
            prev_known_reg    <= 1'b0;
            prev_on_reg       <= 1'b0;
            yaw_accum_reg     <= 16'd0;
            out_valid_reg     <= 1'b0;
            cur_reg           <= '0;
            stick_idx_reg     <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                stick_reg[i] <= '0;
            end
            iter_reg          <= 4'd0;
            cx_reg            <= '0;
            cy_reg            <= '0;
            cz_reg            <= '0;
            cneg_reg          <= 1'b0;
            cos_reg           <= '0;
            sin_reg           <= '0;
            rot_idx_reg       <= 2'd0;
            acc_reg           <= '0;
            vn_reg            <= '0;
            ve_reg            <= '0;
            sc_idx_reg        <= 2'd0;
            vn_out_reg        <= '0;
            ve_out_reg        <= '0;
            vd_out_reg        <= '0;
            out_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cur_reg       <= in_item;
                        stick_idx_reg <= 2'd0;
                        if (in_item.action == ACT_AXIS
                            && {1'b0, in_item.number} < 9'(NUM_AXES))
                        begin
                            axis_reg[in_item.number[AXW-1:0]] <= in_item.value;
                            if (in_item.number == 8'd4)
                            begin
                                switch_seen_reg <= 1'b1;
                            end
                        end
                        else if (in_item.action == ACT_BUTTON && !radio
                                 && in_item.value != 16'sd0)
                        begin
                            if (in_item.number == 8'd0)
                            begin
                                armed_reg <= 1'b1;
                            end
                            else if (in_item.number == 8'd1)
                            begin
                                armed_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_STICK:
                begin
                    stick_reg[stick_idx_reg] <= shaped_val;
                    stick_idx_reg <= stick_idx_reg + 2'd1;
                end
                ST_ARM:
                begin
                    if (radio && switch_seen_reg)
                    begin
                        logic sw;
                        logic edge_seen;
                        sw = ($signed(axis_reg[4]) > 16'sd0);
                        edge_seen = prev_known_reg && !prev_on_reg;
                        if (!sw)
                        begin
                            armed_reg   <= 1'b0;
                            refused_reg <= 1'b0;
                        end
                        else if (edge_seen && stick_reg[0] == 17'sd0)
                        begin
                            armed_reg <= 1'b1;
                        end
                        else if (edge_seen)
                        begin
                            refused_reg <= 1'b1;
                        end
                        prev_known_reg <= 1'b1;
                        prev_on_reg    <= sw;
                    end
                    vn_out_reg <= '0;
                    ve_out_reg <= '0;
                    vd_out_reg <= '0;
                end
                ST_YAW:
                begin
                    logic [15:0] base;
                    logic [15:0] ny;
                    base = (!armed_reg || !heading_known_reg) ? cur_reg.vehicle_yaw
                                                              : yaw_accum_reg;
                    ny = base + yaw_rounded[15:0];
                    yaw_accum_reg     <= ny;
                    heading_known_reg <= 1'b1;
                    iter_reg <= 4'd0;
                    cx_reg   <= 33'sd652032874;
                    cy_reg   <= 33'sd0;
                    if ($signed(ny) > 16'sd16384)
                    begin
                        cz_reg   <= $signed(ny) - 16'sd32767 - 16'sd1;
                        cneg_reg <= 1'b1;
                    end
                    else if ($signed(ny) < -16'sd16384)
                    begin
                        cz_reg   <= $signed(ny) + 16'sd32767 + 16'sd1;
                        cneg_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg   <= ny;
                        cneg_reg <= 1'b0;
                    end
                end
                ST_CORDIC:
                begin
                    if (iter_reg == 4'(CORDIC_STEPS))
                    begin
                        logic signed [35:0] xr, yr;
                        xr = cneg_reg ? -cx_rnd : cx_rnd;
                        yr = cneg_reg ? -cy_rnd : cy_rnd;
                        cos_reg <= (xr > 36'sd32767) ? 17'sd32767 :
                                   ((xr < -36'sd32767) ? -17'sd32767 : xr[16:0]);
                        sin_reg <= (yr > 36'sd32767) ? 17'sd32767 :
                                   ((yr < -36'sd32767) ? -17'sd32767 : yr[16:0]);
                        rot_idx_reg <= 2'd0;
                    end
                    else
                    begin
                        if (!cz_reg[15])
                        begin
                            cx_reg <= cx_reg - sh_y;
                            cy_reg <= cy_reg + sh_x;
                            cz_reg <= cz_reg - atan_v;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + sh_y;
                            cy_reg <= cy_reg - sh_x;
                            cz_reg <= cz_reg + atan_v;
                        end
                        iter_reg <= iter_reg + 4'd1;
                    end
                end
                ST_ROT:
                begin
                    unique case (rot_idx_reg)
                        2'd0:    acc_reg <= mul_p[34:0];
                        2'd1:    vn_reg  <= {acc_reg[34], acc_reg} - mul_p;
                        2'd2:    acc_reg <= mul_p[34:0];
                        default: ve_reg  <= {acc_reg[34], acc_reg} + mul_p;
                    endcase
                    rot_idx_reg <= rot_idx_reg + 2'd1;
                    sc_idx_reg  <= 2'd0;
                end
                ST_SCALE:
                begin
                    if (sc_idx_reg[0])
                    begin
                        ve_out_reg <= rnd30_sat(sc_full);
                    end
                    else
                    begin
                        vn_out_reg <= rnd30_sat(sc_full);
                    end
                    sc_idx_reg <= sc_idx_reg + 2'd1;
                end
                ST_DOWN:
                begin
                    vd_out_reg <= sat15(yaw_rounded);
                    if (armed_reg)
                    begin
                        engaged_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.send_command  <= cur_reg.estimate_valid && engaged_reg;
                        out_reg.mode_fly      <= armed_reg;
                        out_reg.vel_north     <= vn_out_reg;
                        out_reg.vel_east      <= ve_out_reg;
                        out_reg.vel_down      <= vd_out_reg;
                        out_reg.yaw_reference <= yaw_accum_reg;
                        out_reg.arm_refused   <= refused_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> hdl/svc_front.sv
// Front part: holds the configuration registers and classifies input items.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_front
    import svc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // Drop unused actions here; everything else goes to the queue.
    logic drop;
    assign drop     = (in_item.action != ACT_AXIS) && (in_item.action != ACT_BUTTON)
                      && (in_item.action != ACT_TICK);
    assign q_valid  = in_valid && !drop;
    assign in_ready = drop || q_ready;
    assign q_item   = in_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapping_radio <= 1'b0;
            cfg_reg.deadband      <= 15'd3277;
            cfg_reg.rescale_gain  <= 16'd36409;
            cfg_reg.speed_max     <= 14'd3000;
            cfg_reg.climb_max     <= 14'd1500;
            cfg_reg.yaw_step      <= 13'd328;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAPPING:  cfg_reg.mapping_radio <= cfg_data[0];
                REG_DEADBAND: cfg_reg.deadband      <= cfg_data[14:0];
                REG_GAIN:     cfg_reg.rescale_gain  <= cfg_data;
                REG_SPEED:    cfg_reg.speed_max     <= cfg_data[13:0];
                REG_CLIMB:    cfg_reg.climb_max     <= cfg_data[13:0];
                REG_YAWSTEP:  cfg_reg.yaw_step      <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> hdl/stick_to_velocity_command_unit.sv
// Top level of the stick to velocity command unit.
// Depends on svc_pkg, svc_front, svc_queue and svc_back.
`timescale 1ns / 1ps

// Channel  | Direction | Contents
// s_axis   | in        | tdata[47:0]: action[1:0], number[9:2], value[25:10],
//          |           |        estimate_valid[26], vehicle_yaw[42:27]
// m_axis   | out       | tdata[63:0]: send_command[0], mode_fly[1], vel_north[16:2],
//          |           |        vel_east[31:17], vel_down[46:32], yaw_reference[62:47],
//          |           |        arm_refused[63]
// cfg      | in        | index[2:0], data[15:0]; ready only while nothing is in flight
//
// An item is registered in the queue on its transfer; an event is then handled in
// the back part's idle step. A tick with a valid estimate runs there through four
// stick shapes, arm, yaw, the CORDIC iterations, four products, two speed scales,
// the down term and the output load. With an invalid estimate, arm leads to output.
// Reset (rst_n, asynchronous) clears axis values, arm state and yaw.
// A two-entry queue parts front and back; the back part holds in its output step
// while an earlier result waits for m_axis_tready.

module stick_to_velocity_command_unit
    import svc_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action, number, value, estimate_valid, vehicle_yaw from bit 0 up
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_command, mode_fly, vel_north, vel_east, vel_down, yaw_reference,
    // arm_refused from bit 0 up
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item, q_in_item, q_out_item;
    logic    q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    result_t res;
    logic    back_busy;
    logic    cfg_write;

    // Accept register writes only while no item is queued or being worked on.
    assign cfg_ready = !back_busy && !q_out_valid;
    assign cfg_write = cfg_valid && cfg_ready;

    // Unpack the transfer fields.
    assign in_item.action         = s_axis_tdata[1:0];
    assign in_item.number         = s_axis_tdata[9:2];
    assign in_item.value          = s_axis_tdata[25:10];
    assign in_item.estimate_valid = s_axis_tdata[26];
    assign in_item.vehicle_yaw    = s_axis_tdata[42:27];

    svc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_item    (q_in_item)
    );

    svc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    svc_back #(
        .NUM_AXES (NUM_AXES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (q_out_valid),
        .in_ready   (q_out_ready),
        .in_item    (q_out_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res),
        .busy       (back_busy)
    );

    // Pack the result fields from bit 0 up.
    assign m_axis_tdata = {
        res.arm_refused,
        res.yaw_reference,
        res.vel_down,
        res.vel_east,
        res.vel_north,
        res.mode_fly,
        res.send_command
    };

endmodule

>>> hdl/svc_checker.sv
// Port-level checker for the stick to velocity command unit, with its bind.
// Depends on the defines header.
`timescale 1ns / 1ps
`include "stick_to_velocity_command_unit_defines.svh"

module svc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Result valid is always driven after reset.
    `SVC_ASSERT_IMPL(a_valid_known, 1'b1, !$isunknown(m_axis_tvalid))
    // A presented result carries fully known fields.
    `SVC_ASSERT_IMPL(a_out_known, m_axis_tvalid, !$isunknown(m_axis_tdata))
    // A waiting input item holds.
    `SVC_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata))
    // A waiting result holds.
    `SVC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind stick_to_velocity_command_unit svc_checker u_svc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
